// ===== hdl/m61p_pkg.sv =====
// Package for the GF(p) / GF(p^2) power block: constants, payload types, sequencer codes.
package m61p_pkg;

	// Mersenne prime p = 2^P_BITS - 1 and the product split
	localparam int P_BITS    = 61;
	localparam int HI_SHIFT  = 58;
	localparam int HALF_BITS = 32;
	localparam int WORD_W    = 64;
	localparam int PROD_W    = 2 * WORD_W;

	// Configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 64;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPLEX  = 1'b1;

	// One input item
	typedef struct packed {
		logic [WORD_W-1:0] base_real;
		logic [WORD_W-1:0] base_imag;
	} in_t;

	// One result item
	typedef struct packed {
		logic [P_BITS-1:0] result_real;
		logic [P_BITS-1:0] result_imag;
	} out_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIT,
		ST_MUL,
		ST_COMB
	} state_t;

	// Modular products: M* belong to the multiply step, S* to the squaring step
	typedef enum logic [2:0] {
		OP_MR,  // cr * br
		OP_MI,  // ci * bi
		OP_MX,  // cr * bi
		OP_MY,  // ci * br
		OP_SR,  // cr * cr
		OP_SI,  // ci * ci
		OP_SX   // cr * ci
	} op_t;

endpackage

// ===== hdl/mersenne61_gfp2_power.sv =====
// Power of a GF(2^61-1) or GF(p^2) element by right-to-left square-and-multiply.
//
//  channel  | handshake        | payload                        | notes
//  ---------+------------------+--------------------------------+---------------------------
//  input    | start / busy     | item  (base_real, base_imag)   | transfer when start & !busy
//  result   | done             | result (result_real, result_imag) | one-cycle strobe
//  config   | cfg_we           | cfg_index, cfg_data            | write, no wait
//
// Each modular product runs on one shared 32x32 multiplier (4 partial products, then a
// 128-bit fold and two Mersenne folds). Per exponent bit up to the highest set bit: real
// mode squares, multiplying first if the bit is set; complex mode does the same with
// 4 multiply or 3 square products, each run closed by ST_COMB. The multiplier sets the rate.
// Reset clears the sequencer and both configuration registers to 0.
// The receiver cannot stall; the next start may be given in the cycle of done.
module mersenne61_gfp2_power (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  m61p_pkg::in_t                       item,
	output logic                                done,
	output m61p_pkg::out_t                      result,
	input  logic                                cfg_we,
	input  logic [m61p_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [m61p_pkg::CFG_W-1:0]          cfg_data
);

	localparam int PW = m61p_pkg::P_BITS;
	localparam int WW = m61p_pkg::WORD_W;
	localparam int HW = m61p_pkg::HALF_BITS;
	localparam int QW = m61p_pkg::PROD_W;
	localparam int FW = WW - PW;

	// One Mersenne fold of a 64-bit word
	function automatic logic [WW-1:0] fold(input logic [WW-1:0] t);
		fold = {{FW{1'b0}}, t[PW-1:0]} + {{PW{1'b0}}, t[WW-1:PW]};
	endfunction

	// Fold of the 128-bit product into a 64-bit word
	function automatic logic [WW-1:0] fold_wide(input logic [QW-1:0] p);
		logic [WW-1:0] lo;
		logic [WW-1:0] hi;
		lo = p[WW-1:0];
		hi = p[QW-1:WW];
		fold_wide = {{FW{1'b0}}, lo[PW-1:0]} + {{PW{1'b0}}, lo[WW-1:PW]}
			+ {hi[m61p_pkg::HI_SHIFT-1:0], {FW{1'b0}}}
			+ {{m61p_pkg::HI_SHIFT{1'b0}}, hi[WW-1:m61p_pkg::HI_SHIFT]};
	endfunction

	function automatic logic [PW-1:0] madd(input logic [PW-1:0] x, input logic [PW-1:0] y);
		logic [WW-1:0] s;
		s = fold({{FW{1'b0}}, x} + {{FW{1'b0}}, y});
		madd = s[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] msub(input logic [PW-1:0] x, input logic [PW-1:0] y);
		logic [WW-1:0] s;
		s = fold({{FW{1'b0}}, x} + {{FW{1'b0}}, ~y});
		msub = s[PW-1:0];
	endfunction

	// Configuration registers
	logic [WW-1:0] exponent_q;
	logic          complex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			complex_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				m61p_pkg::REG_EXPONENT: exponent_q <= cfg_data;
				m61p_pkg::REG_COMPLEX:  complex_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and working registers
	m61p_pkg::state_t state_q, state_d;
	m61p_pkg::op_t    op_q, op_d;
	logic [2:0]       ph_q;
	logic [WW-1:0]    k_q;
	logic             cplx_q;
	logic             done_q;
	m61p_pkg::out_t   result_q;

	logic [WW-1:0]    cr_q, ci_q;
	logic [PW-1:0]    br_q, bi_q;
	logic [PW-1:0]    m0_q, m1_q, m2_q, m3_q;

	logic [WW-1:0]    prod_q;
	logic [QW-1:0]    acc_q;
	logic [WW-1:0]    t_q;

	logic             accept;
	logic             finish;
	logic             shift_k;

	// Next state and sequencing
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		accept  = 1'b0;
		finish  = 1'b0;
		shift_k = 1'b0;
		unique case (state_q)
			m61p_pkg::ST_IDLE: begin
				if (start) begin
					accept  = 1'b1;
					state_d = m61p_pkg::ST_BIT;
				end
			end
			m61p_pkg::ST_BIT: begin
				if (k_q == '0) begin
					finish  = 1'b1;
					state_d = m61p_pkg::ST_IDLE;
				end else begin
					op_d    = k_q[0] ? m61p_pkg::OP_MR : m61p_pkg::OP_SR;
					state_d = m61p_pkg::ST_MUL;
				end
			end
			m61p_pkg::ST_MUL: begin
				if (ph_q == 3'd7) begin
					if (!cplx_q) begin
						if (op_q == m61p_pkg::OP_MR) begin
							op_d = m61p_pkg::OP_SR;
						end else begin
							shift_k = 1'b1;
							state_d = m61p_pkg::ST_BIT;
						end
					end else begin
						unique case (op_q)
							m61p_pkg::OP_MR: op_d = m61p_pkg::OP_MI;
							m61p_pkg::OP_MI: op_d = m61p_pkg::OP_MX;
							m61p_pkg::OP_MX: op_d = m61p_pkg::OP_MY;
							m61p_pkg::OP_SR: op_d = m61p_pkg::OP_SI;
							m61p_pkg::OP_SI: op_d = m61p_pkg::OP_SX;
							default:         state_d = m61p_pkg::ST_COMB;
						endcase
					end
				end
			end
			m61p_pkg::ST_COMB: begin
				if (op_q == m61p_pkg::OP_MY) begin
					op_d    = m61p_pkg::OP_SR;
					state_d = m61p_pkg::ST_MUL;
				end else begin
					shift_k = 1'b1;
					state_d = m61p_pkg::ST_BIT;
				end
			end
			default: state_d = m61p_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m61p_pkg::ST_IDLE;
			op_q    <= m61p_pkg::OP_MR;
			ph_q    <= '0;
			k_q     <= '0;
			cplx_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			done_q  <= finish;
			if (state_q == m61p_pkg::ST_MUL) begin
				ph_q <= ph_q + 3'd1;
			end
			if (accept) begin
				k_q    <= exponent_q;
				cplx_q <= complex_q;
			end else if (shift_k) begin
				k_q <= k_q >> 1;
			end
		end
	end

	// Operand select for the shared multiplier
	logic [WW-1:0] a_op, b_op;
	logic [HW-1:0] a_half, b_half;
	logic [QW-1:0] addend;

	always_comb begin
		unique case (op_q)
			m61p_pkg::OP_MR: begin a_op = cr_q; b_op = {{FW{1'b0}}, br_q}; end
			m61p_pkg::OP_MI: begin a_op = ci_q; b_op = {{FW{1'b0}}, bi_q}; end
			m61p_pkg::OP_MX: begin a_op = cr_q; b_op = {{FW{1'b0}}, bi_q}; end
			m61p_pkg::OP_MY: begin a_op = ci_q; b_op = {{FW{1'b0}}, br_q}; end
			m61p_pkg::OP_SR: begin a_op = cr_q; b_op = cr_q; end
			m61p_pkg::OP_SI: begin a_op = ci_q; b_op = ci_q; end
			m61p_pkg::OP_SX: begin a_op = cr_q; b_op = ci_q; end
			default:         begin a_op = cr_q; b_op = ci_q; end
		endcase
		// phase 0: a0*b0, 1: a1*b0, 2: a0*b1, 3: a1*b1
		a_half = ph_q[0] ? a_op[WW-1:HW] : a_op[HW-1:0];
		b_half = ph_q[1] ? b_op[WW-1:HW] : b_op[HW-1:0];
		// weight of the partial product taken last cycle
		case (ph_q)
			3'd1:       addend = {{WW{1'b0}}, prod_q};
			3'd2, 3'd3: addend = {{HW{1'b0}}, prod_q, {HW{1'b0}}};
			default:    addend = {prod_q, {WW{1'b0}}};
		endcase
	end

	logic [WW-1:0] r_full;
	logic [PW-1:0] r_mod;
	assign r_full = fold(t_q);
	assign r_mod  = r_full[PW-1:0];

	// Multiplier, accumulator and fold pipeline
	always_ff @(posedge clk) begin
		if (state_q == m61p_pkg::ST_MUL) begin
			if (ph_q < 3'd4) begin
				prod_q <= {{HW{1'b0}}, a_half} * {{HW{1'b0}}, b_half};
			end
			if (ph_q == 3'd0) begin
				acc_q <= '0;
			end else if (ph_q <= 3'd4) begin
				acc_q <= acc_q + addend;
			end
			if (ph_q == 3'd5) begin
				t_q <= fold_wide(acc_q);
			end else if (ph_q == 3'd6) begin
				t_q <= fold(t_q);
			end
		end
	end

	// Element registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cr_q <= item.base_real;
			ci_q <= item.base_imag;
			br_q <= {{(PW-1){1'b0}}, 1'b1};
			bi_q <= '0;
		end else if (state_q == m61p_pkg::ST_MUL && ph_q == 3'd7) begin
			if (!cplx_q) begin
				if (op_q == m61p_pkg::OP_MR) begin
					br_q <= r_mod;
				end else begin
					cr_q <= {{FW{1'b0}}, r_mod};
				end
			end else begin
				unique case (op_q)
					m61p_pkg::OP_MR, m61p_pkg::OP_SR: m0_q <= r_mod;
					m61p_pkg::OP_MI, m61p_pkg::OP_SI: m1_q <= r_mod;
					m61p_pkg::OP_MX, m61p_pkg::OP_SX: m2_q <= r_mod;
					default:                          m3_q <= r_mod;
				endcase
			end
		end else if (state_q == m61p_pkg::ST_COMB) begin
			if (op_q == m61p_pkg::OP_MY) begin
				br_q <= msub(m0_q, m1_q);
				bi_q <= madd(m2_q, m3_q);
			end else begin
				// cr*ci and ci*cr are the same product
				cr_q <= {{FW{1'b0}}, msub(m0_q, m1_q)};
				ci_q <= {{FW{1'b0}}, madd(m2_q, m2_q)};
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.result_real <= br_q;
			result_q.result_imag <= bi_q;
		end
	end

	assign busy   = (state_q != m61p_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/m61p_check.sv =====
// Port-level checker for the power block, bound to the top level.
module m61p_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  m61p_pkg::in_t                  item,
	input  logic                           done,
	input  m61p_pkg::out_t                 result,
	input  logic                           cfg_we,
	input  logic [m61p_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [m61p_pkg::CFG_W-1:0]     cfg_data
);

	// a transfer on the input side makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after input transfer");

	// a result appears only once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// busy ends only together with a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// one result per item: strobes never run back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

endmodule

bind mersenne61_gfp2_power m61p_check u_m61p_check (.*);
